// File: hdl/rokt_pkg.sv
package rokt_pkg;

  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_READ   = 1'b1;

  localparam logic [7:0] MISS_DIRECTION = 8'hff;

  typedef struct packed {
    logic [31:0] key;
    logic [15:0] floor;
    logic [47:0] zone;
    logic [7:0]  direction;
  } rec_t;

  // Walk token handed from cell to cell along with the carried record
  typedef struct packed {
    logic valid;
    logic active;
    logic is_read;
    logic grow;
    logic found;
  } tok_t;

endpackage

// File: hdl/recency_ordered_keyed_table_unit.sv
// Keyed record table kept in recency order, most recent entry at position 0.
// Input channel: in_valid / in_stall with opcode, record fields and read index.
//   Update (opcode 0): drop any entry with the same key, drop the oldest entry
//   if still full, put the new record at the front.
//   Read (opcode 1): return the record read_index places from the front, or a
//   zeroed record with direction 0xff and found low when there is none.
// Result channel: out_valid / out_stall, one word per input word, carrying the
//   entry count after the item.
// Walk: an accepted item is registered at the head, walks the row of cells
//   one cell per cycle, and its result is then registered in the output register.
//   The next item is taken only once the walk is over, so items never overlap
//   inside the row of cells.
// Stall: a finished result waits in the output register; a new item is taken
//   as soon as that register is empty or being drained in the same cycle.
// Reset: the table is empty after reset; record storage itself is not cleared.
module recency_ordered_keyed_table_unit #(
  parameter int ENTRIES = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_opcode,
  input  logic [31:0] in_rec_key,
  input  logic [15:0] in_rec_floor,
  input  logic [47:0] in_rec_zone,
  input  logic [7:0]  in_rec_direction,
  input  logic [1:0]  in_read_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_found,
  output logic [31:0] out_key,
  output logic [15:0] out_floor,
  output logic [47:0] out_zone,
  output logic [7:0]  out_direction,
  output logic [2:0]  out_entry_count
);
  import rokt_pkg::*;

  localparam int CW = $clog2(ENTRIES + 1);

  logic          in_accept;
  logic          out_take;
  logic          walk_r;
  logic [CW-1:0] count_r, count_nxt;
  tok_t          head_tok_r;
  rec_t          head_rec_r;
  logic [31:0]   item_key_r;
  logic [1:0]    rd_idx_r;
  logic          out_valid_r;
  logic          found_r;
  rec_t          out_rec_r;
  logic [2:0]    entry_count_r;

  tok_t          tok_link [ENTRIES+1];
  rec_t          rec_link [ENTRIES+1];
  logic [ENTRIES-1:0] occ;
  tok_t          tail_tok;
  rec_t          tail_rec;

  assign in_stall  = walk_r | (out_valid_r & out_stall);
  assign in_accept = in_valid & ~in_stall;
  assign out_take  = out_valid_r & ~out_stall;

  assign tok_link[0] = head_tok_r;
  assign rec_link[0] = head_rec_r;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    assign occ[g] = (CW'(g) < count_r);
    rokt_cell #(.IDX(g)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .occ      (occ[g]),
      .item_key (item_key_r),
      .rd_idx   (rd_idx_r),
      .tok_in   (tok_link[g]),
      .carry_in (rec_link[g]),
      .tok_out  (tok_link[g+1]),
      .carry_out(rec_link[g+1])
    );
  end

  assign tail_tok = tok_link[ENTRIES];
  assign tail_rec = rec_link[ENTRIES];

  always_comb begin
    count_nxt = count_r;
    if (tail_tok.valid && tail_tok.grow) begin
      count_nxt = count_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      walk_r      <= 1'b0;
      count_r     <= '0;
      head_tok_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_tok_r <= '{valid: in_accept, active: in_accept,
                      is_read: in_accept && (in_opcode == OP_READ),
                      grow: 1'b0, found: 1'b0};
      if (in_accept) begin
        walk_r <= 1'b1;
      end
      if (out_take) begin
        out_valid_r <= 1'b0;
      end
      if (tail_tok.valid) begin
        walk_r      <= 1'b0;
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      head_rec_r <= '{key: in_rec_key, floor: in_rec_floor, zone: in_rec_zone,
                      direction: in_rec_direction};
      item_key_r <= in_rec_key;
      rd_idx_r   <= in_read_index;
    end
    if (tail_tok.valid) begin
      entry_count_r <= 3'(count_nxt);
      if (!tail_tok.is_read) begin
        found_r   <= 1'b1;
        out_rec_r <= '0;
      end else if (tail_tok.found) begin
        found_r   <= 1'b1;
        out_rec_r <= tail_rec;
      end else begin
        found_r   <= 1'b0;
        out_rec_r <= '{key: '0, floor: '0, zone: '0, direction: MISS_DIRECTION};
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_found       = found_r;
  assign out_key         = out_rec_r.key;
  assign out_floor       = out_rec_r.floor;
  assign out_zone        = out_rec_r.zone;
  assign out_direction   = out_rec_r.direction;
  assign out_entry_count = entry_count_r;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(ENTRIES))
    else $error("entry count beyond table size");

  a_tail_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    tail_tok.valid |-> walk_r)
    else $error("walk token left the chain with no walk in progress");

  a_grow_room: assert property (@(posedge clk) disable iff (!rst_n)
    (tail_tok.valid && tail_tok.grow) |-> (count_r < CW'(ENTRIES)))
    else $error("table grew while full");

  a_read_no_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (tail_tok.valid && tail_tok.is_read) |-> !tail_tok.grow)
    else $error("read changed the entry count");

  a_out_from_tail: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(tail_tok.valid))
    else $error("result raised without a finished walk");
`endif

endmodule

// File: hdl/rokt_cell.sv
module rokt_cell #(
  parameter int IDX = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          occ,
  input  logic [31:0]   item_key,
  input  logic [1:0]    rd_idx,
  input  rokt_pkg::tok_t tok_in,
  input  rokt_pkg::rec_t carry_in,
  output rokt_pkg::tok_t tok_out,
  output rokt_pkg::rec_t carry_out
);
  import rokt_pkg::*;

  localparam bit         IDX_NEAR = (IDX < 4);
  localparam logic [1:0] IDX_LO   = 2'(IDX % 4);

  rec_t rec_r, rec_nxt;
  tok_t tok_r, tok_nxt;
  rec_t carry_r, carry_nxt;
  logic rd_hit;

  assign rd_hit = IDX_NEAR && (rd_idx == IDX_LO);

  always_comb begin
    rec_nxt   = rec_r;
    tok_nxt   = tok_in;
    carry_nxt = carry_in;
    if (tok_in.valid && tok_in.active) begin
      if (tok_in.is_read) begin
        if (rd_hit && occ) begin
          carry_nxt      = rec_r;
          tok_nxt.active = 1'b0;
          tok_nxt.found  = 1'b1;
        end
      end else begin
        // take the carried word; hand our own on unless this cell is empty
        rec_nxt = carry_in;
        if (!occ) begin
          tok_nxt.active = 1'b0;
          tok_nxt.grow   = 1'b1;
        end else begin
          carry_nxt = rec_r;
          if (rec_r.key == item_key) begin
            tok_nxt.active = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rec_r   <= rec_nxt;
    carry_r <= carry_nxt;
  end

  assign tok_out   = tok_r;
  assign carry_out = carry_r;

endmodule
